// ----- hw/rtl/fct_pkg.sv -----
`default_nettype none

package fct_pkg;

  localparam int unsigned PlaneCount = 6;
  localparam int unsigned CfgIdxW    = $clog2(PlaneCount);
  localparam int unsigned PlaneW     = 64;
  localparam int unsigned CoefW      = 16;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned ExtW       = 15;
  localparam int unsigned FracShift  = 14;
  localparam int unsigned ProdW      = 32;
  localparam int unsigned DistW      = 34;
  localparam int unsigned MarginW    = 32;
  localparam int unsigned SumW       = 35;

  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_SPHERE = 2'd1,
    KIND_BOX    = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_z;
    logic [ExtW-1:0]   ext_x;
    logic [ExtW-1:0]   ext_y;
    logic [ExtW-1:0]   ext_z;
  } obj_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fct_plane.sv -----
`default_nettype none

module fct_plane
  import fct_pkg::*;
(
  input  logic              clk_i,
  input  obj_t              obj_i,
  input  logic [PlaneW-1:0] plane_i,
  output logic              cull_o
);

  localparam int unsigned MagW   = CoefW + 1;
  localparam int unsigned DExtW  = DistW - CoefW - FracShift;
  localparam int unsigned EPadW  = MarginW - ExtW - FracShift;

  logic signed [CoefW-1:0] coef_a, coef_b, coef_c;
  logic signed [MagW-1:0]  a_ext, b_ext, c_ext;
  logic [MagW-1:0]         mag_a, mag_b, mag_c;

  logic signed [ProdW-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic [ProdW-1:0]        mprod_x_q, mprod_y_q, mprod_z_q;
  logic [CoefW-1:0]        d_q;
  kind_e                   kind_q;
  logic [ExtW-1:0]         ext_q;

  logic signed [DistW-1:0] dist_d, dist_q;
  logic [MarginW-1:0]      margin_d, margin_q;
  logic signed [SumW-1:0]  sum;

  assign coef_a = $signed(plane_i[CoefW-1:0]);
  assign coef_b = $signed(plane_i[2*CoefW-1:CoefW]);
  assign coef_c = $signed(plane_i[3*CoefW-1:2*CoefW]);

  assign a_ext = MagW'(coef_a);
  assign b_ext = MagW'(coef_b);
  assign c_ext = MagW'(coef_c);

  assign mag_a = a_ext[MagW-1] ? MagW'(-a_ext) : MagW'(a_ext);
  assign mag_b = b_ext[MagW-1] ? MagW'(-b_ext) : MagW'(b_ext);
  assign mag_c = c_ext[MagW-1] ? MagW'(-c_ext) : MagW'(c_ext);

  always_ff @(posedge clk_i) begin
    prod_x_q  <= ProdW'(coef_a) * ProdW'($signed(obj_i.pos_x));
    prod_y_q  <= ProdW'(coef_b) * ProdW'($signed(obj_i.pos_y));
    prod_z_q  <= ProdW'(coef_c) * ProdW'($signed(obj_i.pos_z));
    mprod_x_q <= ProdW'(mag_a) * ProdW'(obj_i.ext_x);
    mprod_y_q <= ProdW'(mag_b) * ProdW'(obj_i.ext_y);
    mprod_z_q <= ProdW'(mag_c) * ProdW'(obj_i.ext_z);
    d_q       <= plane_i[PlaneW-1:3*CoefW];
    kind_q    <= obj_i.kind;
    ext_q     <= obj_i.ext_x;
  end

  always_comb begin
    dist_d = DistW'(prod_x_q) + DistW'(prod_y_q) + DistW'(prod_z_q)
           + $signed({{DExtW{d_q[CoefW-1]}}, d_q, {FracShift{1'b0}}});
    case (kind_q)
      KIND_POINT:  margin_d = '0;
      KIND_SPHERE: margin_d = {{EPadW{1'b0}}, ext_q, {FracShift{1'b0}}};
      default:     margin_d = mprod_x_q + mprod_y_q + mprod_z_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    dist_q   <= dist_d;
    margin_q <= margin_d;
  end

  assign sum    = SumW'(dist_q) + $signed({{(SumW-MarginW){1'b0}}, margin_q});
  assign cull_o = sum[SumW-1];

endmodule

`default_nettype wire

// ----- hw/rtl/frustum_cull_test.sv -----
// Channel  Handshake                  Payload
// input    start_i (busy_o is low)    kind_i, pos_{x,y,z}_i, extent_{x,y,z}_i
// result   valid_o strobe, 1 cycle    inside_res_o
// config   cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One item is accepted per cycle; busy_o stays low.
// From accept to the valid_o strobe the path runs: input register,
// signed 16x16 distance products and margin products per plane, distance and margin sums, sign test and AND.
// Reset clears the six plane registers and the valid bits.
// Results cannot be stalled; each leaves on valid_o for one cycle.
`default_nettype none

module frustum_cull_test
  import fct_pkg::*;
#(
  parameter int unsigned NumPlanes = PlaneCount
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              kind_i,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic signed [CoordW-1:0] pos_z_i,
  input  logic [ExtW-1:0]         extent_x_i,
  input  logic [ExtW-1:0]         extent_y_i,
  input  logic [ExtW-1:0]         extent_z_i,
  output logic                    valid_o,
  output logic                    inside_res_o,
  input  logic                    cfg_we_i,
  input  logic [$clog2(NumPlanes)-1:0] cfg_idx_i,
  input  logic [PlaneW-1:0]       cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(NumPlanes);

  logic [PlaneW-1:0] plane_q [NumPlanes];
  obj_t              obj_q;
  logic [3:0]        vld_q;
  logic [NumPlanes-1:0] cull;
  logic              inside_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPlanes; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < NumPlanes; i++) begin
        if (cfg_idx_i == IdxW'(i)) begin
          plane_q[i] <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    obj_q.kind  <= kind_e'(kind_i);
    obj_q.pos_x <= pos_x_i;
    obj_q.pos_y <= pos_y_i;
    obj_q.pos_z <= pos_z_i;
    obj_q.ext_x <= extent_x_i;
    obj_q.ext_y <= extent_y_i;
    obj_q.ext_z <= extent_z_i;
    inside_q    <= ~|cull;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  for (genvar g = 0; g < NumPlanes; g++) begin : g_plane
    fct_plane u_plane (
      .clk_i   (clk_i),
      .obj_i   (obj_q),
      .plane_i (plane_q[g]),
      .cull_o  (cull[g])
    );
  end

  assign valid_o      = vld_q[3];
  assign inside_res_o = inside_q;

endmodule

`default_nettype wire

// ----- verif/frustum_cull_test_tb.sv -----
`default_nettype none

module frustum_cull_test_tb
  import fct_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OneQ = 1 << FracShift;
  localparam int PosMax = 32767;
  localparam int PosMin = -32768;
  localparam int ExtMax = 32767;
  localparam logic [1:0] KindSpare = 2'd3;

  typedef struct {
    logic [1:0]        kind;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_z;
    logic [ExtW-1:0]   ext_x;
    logic [ExtW-1:0]   ext_y;
    logic [ExtW-1:0]   ext_z;
  } cull_obj_t;

  typedef logic [PlaneW-1:0] frustum_t [PlaneCount];

  class visibility_board;
    logic [PlaneW-1:0] planes [PlaneCount];
    bit verdict_q [$];
    int errors;

    function new();
      foreach (planes[i]) planes[i] = '0;
      errors = 0;
    endfunction

    function void load_plane(int idx, logic [PlaneW-1:0] word);
      planes[idx] = word;
    endfunction

    function bit predict_visible(cull_obj_t o);
      longint a, b, c, d, px, py, pz, ex, ey, ez, distance, margin;
      bit visible;
      visible = 1'b1;
      px = $signed(o.pos_x);
      py = $signed(o.pos_y);
      pz = $signed(o.pos_z);
      ex = o.ext_x;
      ey = o.ext_y;
      ez = o.ext_z;
      for (int i = 0; i < PlaneCount; i++) begin
        a = $signed(planes[i][15:0]);
        b = $signed(planes[i][31:16]);
        c = $signed(planes[i][47:32]);
        d = $signed(planes[i][63:48]);
        distance = a * px + b * py + c * pz + d * OneQ;
        case (o.kind)
          KIND_POINT: margin = 0;
          KIND_SPHERE: margin = ex * OneQ;
          default: begin
            margin = (a < 0 ? -a : a) * ex + (b < 0 ? -b : b) * ey + (c < 0 ? -c : c) * ez;
          end
        endcase
        if (distance < -margin) visible = 1'b0;
      end
      return visible;
    endfunction

    function void note_object(cull_obj_t o);
      verdict_q.push_back(predict_visible(o));
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual inside_res=%b", $time, got);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (got !== want) begin
        $display("%0t: inside_res mismatch, expected %b, actual %b", $time, want, got);
        errors++;
      end
    endfunction

    function int waiting();
      return verdict_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [1:0]            kind_i;
  logic [CoordW-1:0]     pos_x_i;
  logic [CoordW-1:0]     pos_y_i;
  logic [CoordW-1:0]     pos_z_i;
  logic [ExtW-1:0]       extent_x_i;
  logic [ExtW-1:0]       extent_y_i;
  logic [ExtW-1:0]       extent_z_i;
  logic                  valid_o;
  logic                  inside_res_o;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_idx_i;
  logic [PlaneW-1:0]     cfg_wdata_i;

  visibility_board board;
  bit start_held;

  frustum_cull_test dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .extent_x_i   (extent_x_i),
    .extent_y_i   (extent_y_i),
    .extent_z_i   (extent_z_i),
    .valid_o      (valid_o),
    .inside_res_o (inside_res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("frustum_cull_test_tb: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && valid_o === 1'b1) board.check_verdict(inside_res_o);
  end

  function automatic logic [PlaneW-1:0] plane_word(int a, int b, int c, int d);
    return {d[15:0], c[15:0], b[15:0], a[15:0]};
  endfunction

  function automatic cull_obj_t mk_object(logic [1:0] k, int x, int y, int z,
                                          int ex, int ey, int ez);
    cull_obj_t o;
    o.kind  = k;
    o.pos_x = x[CoordW-1:0];
    o.pos_y = y[CoordW-1:0];
    o.pos_z = z[CoordW-1:0];
    o.ext_x = ex[ExtW-1:0];
    o.ext_y = ey[ExtW-1:0];
    o.ext_z = ez[ExtW-1:0];
    return o;
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(1)) return $urandom;
    return int'($urandom_range(0, 16000)) - 8000;
  endfunction

  function automatic int rand_extent();
    if ($urandom_range(9) < 3) return $urandom;
    return $urandom_range(0, 3000);
  endfunction

  function automatic cull_obj_t rand_object();
    return mk_object($urandom_range(3), rand_coord(), rand_coord(), rand_coord(),
                     rand_extent(), rand_extent(), rand_extent());
  endfunction

  // box-shaped frustum: one main axis per plane pair, small tilt on the others
  function automatic frustum_t axis_frustum(int span_lo, int span_hi, int tilt);
    frustum_t f;
    int co [3];
    for (int i = 0; i < PlaneCount; i++) begin
      for (int j = 0; j < 3; j++) co[j] = int'($urandom_range(0, 2 * tilt)) - tilt;
      co[i / 2] = (i % 2) ? -OneQ : OneQ;
      f[i] = plane_word(co[0], co[1], co[2], $urandom_range(span_lo, span_hi));
    end
    return f;
  endfunction

  function automatic frustum_t uniform_frustum(int v);
    frustum_t f;
    foreach (f[i]) f[i] = plane_word(v, v, v, v);
    return f;
  endfunction

  function automatic frustum_t wild_frustum();
    frustum_t f;
    foreach (f[i]) f[i] = {$urandom, $urandom};
    return f;
  endfunction

  task automatic send_object(input cull_obj_t o, input int idle_pct);
    start_i    <= 1'b1;
    start_held  = 1'b1;
    kind_i     <= o.kind;
    pos_x_i    <= o.pos_x;
    pos_y_i    <= o.pos_y;
    pos_z_i    <= o.pos_z;
    extent_x_i <= o.ext_x;
    extent_y_i <= o.ext_y;
    extent_z_i <= o.ext_z;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    board.note_object(o);
    if ($urandom_range(99) < idle_pct) begin
      start_i    <= 1'b0;
      start_held  = 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic quiesce();
    if (start_held) begin
      start_i    <= 1'b0;
      start_held  = 1'b0;
    end
    @(posedge clk_i);
    while (board.waiting() != 0) @(posedge clk_i);
  endtask

  task automatic set_frustum(input frustum_t f);
    for (int i = 0; i < PlaneCount; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CfgIdxW'(i);
      cfg_wdata_i <= f[i];
      @(posedge clk_i);
      board.load_plane(i, f[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_list(input cull_obj_t list [$]);
    foreach (list[i]) send_object(list[i], 0);
  endtask

  initial begin
    cull_obj_t dq [$];
    int idle_modes [3];
    idle_modes = '{31, 74, 0};
    board = new();
    start_held = 1'b0;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    kind_i      <= '0;
    pos_x_i     <= '0;
    pos_y_i     <= '0;
    pos_z_i     <= '0;
    extent_x_i  <= '0;
    extent_y_i  <= '0;
    extent_z_i  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dq = {};
    dq.push_back(mk_object(KIND_POINT, PosMax, PosMax, PosMax, 0, 0, 0));
    dq.push_back(mk_object(KIND_SPHERE, PosMin, PosMin, PosMin, ExtMax, 0, 0));
    dq.push_back(mk_object(KIND_BOX, PosMax, PosMin, PosMax, ExtMax, ExtMax, ExtMax));
    dq.push_back(mk_object(KindSpare, PosMin, PosMax, PosMin, ExtMax, ExtMax, ExtMax));
    send_list(dq);

    quiesce();
    set_frustum(uniform_frustum(PosMin));
    dq = {};
    dq.push_back(mk_object(KIND_POINT, 0, 0, 0, ExtMax, ExtMax, ExtMax));
    dq.push_back(mk_object(KIND_SPHERE, 0, 0, 0, ExtMax, 0, 0));
    dq.push_back(mk_object(KIND_BOX, 0, 0, 0, ExtMax, ExtMax, ExtMax));
    dq.push_back(mk_object(KindSpare, 0, 0, 0, ExtMax, ExtMax, ExtMax));
    dq.push_back(mk_object(KIND_BOX, PosMin, PosMin, PosMin, 0, 0, 0));
    dq.push_back(mk_object(KIND_POINT, PosMax, PosMax, PosMax, 0, 0, 0));
    send_list(dq);

    quiesce();
    set_frustum(uniform_frustum(PosMax));
    dq = {};
    dq.push_back(mk_object(KIND_POINT, PosMax, PosMax, PosMax, 0, 0, 0));
    dq.push_back(mk_object(KIND_POINT, PosMin, PosMin, PosMin, 0, 0, 0));
    dq.push_back(mk_object(KIND_BOX, PosMin, PosMin, PosMin, ExtMax, ExtMax, ExtMax));
    dq.push_back(mk_object(KIND_SPHERE, PosMin, PosMin, PosMin, 0, ExtMax, ExtMax));
    send_list(dq);

    quiesce();
    set_frustum(axis_frustum(400, 400, 0));
    dq = {};
    dq.push_back(mk_object(KIND_POINT, -400, 0, 0, 0, 0, 0));
    dq.push_back(mk_object(KIND_POINT, -401, 0, 0, 0, 0, 0));
    dq.push_back(mk_object(KIND_SPHERE, -410, 0, 0, 10, 0, 0));
    dq.push_back(mk_object(KIND_SPHERE, -410, 0, 0, 9, 0, 0));
    dq.push_back(mk_object(KIND_BOX, -410, 0, 0, 10, 0, 0));
    dq.push_back(mk_object(KIND_BOX, -410, 0, 0, 9, 0, 0));
    send_list(dq);

    foreach (idle_modes[m]) begin
      for (int s = 0; s < 3; s++) begin
        quiesce();
        case (s)
          0: set_frustum(axis_frustum(500, 3000, 600));
          1: set_frustum(axis_frustum(8000, PosMax, 4000));
          default: set_frustum(wild_frustum());
        endcase
        repeat (167) send_object(rand_object(), idle_modes[m]);
      end
    end

    quiesce();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.waiting() == 0) begin
      $display("frustum_cull_test_tb: clean");
    end else begin
      $display("frustum_cull_test_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
